// ----- rtl/rrs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrs_pkg
// shared types and codes for the round-robin slice scheduler
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned CLOCK_W = 32;
  localparam int unsigned TIME_W  = 16;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_GRANT = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic REG_QUANTUM    = 1'b0;
  localparam logic REG_TASK_COUNT = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [CLOCK_W-1:0]  a;
    logic [CLOCK_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic [CLOCK_W-1:0]  sum;
    logic                carry;
  } alu_rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0]   arrival;
    logic [TIME_W-1:0]   burst;
    logic [TIME_W-1:0]   remaining;
  } entry_t;

endpackage

// ----- rtl/round_robin_slice_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_core
// round-robin time-slice scheduler over a table of task slots
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. Its single
// result is shown on the result ports with strobe high for one cycle, in the
// cycle right after the command completes, and must be taken then, as the
// receiver cannot stall. A load, or an advance when every task has finished,
// completes at the accepting edge, so busy never rises. Any other advance
// holds busy high while it walks the slot table through its single read port:
// a scan and a check state per slot examined, a further scan state at each
// end of pass, then a run state for the slice and three finish states
// when the task finishes, or a tick state for an idle tick. Clock and time
// arithmetic goes through one shared add/subtract unit. The table needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_core import rrs_pkg::*; #(
  parameter int unsigned MAX_TASKS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                func,
  input  logic [5:0]          slot,
  input  logic [15:0]         arrival,
  input  logic [15:0]         burst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                strobe,
  output logic [1:0]          kind,
  output logic [6:0]          task_number,
  output logic [31:0]         clock_after,
  output logic                finished,
  output logic [31:0]         waiting_time,
  output logic [31:0]         turnaround_time
);

  localparam int unsigned IW  = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW  = ($clog2(MAX_TASKS + 1) > 7) ? $clog2(MAX_TASKS + 1) : 7;
  localparam int unsigned SLW = (IW > 6) ? IW : 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_RUN,
    S_FIN1,
    S_FIN2,
    S_FIN3,
    S_TICK
  } state_t;

  state_t              state;
  logic [15:0]         quantum;
  logic [6:0]          task_count;
  logic [31:0]         clock_now;
  logic [IW-1:0]       scan_position;
  logic                pass_found_any;
  logic [6:0]          completed_count;
  logic [CW-1:0]       idx;
  logic                second_pass;
  logic [31:0]         tmp;

  entry_t              mem [MAX_TASKS];
  entry_t              rdata;
  logic                rd_en;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  entry_t              mem_wdata;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  logic [CW-1:0]       tc_wide;
  logic [CW-1:0]       n_eff;
  logic [SLW-1:0]      slot_wide;
  logic [IW-1:0]       slot_addr;
  logic                slot_in_range;
  logic                accept;
  logic [15:0]         quantum_eff;
  logic [15:0]         run;
  logic [15:0]         rem_next;
  logic [31:0]         clock_sat;
  logic [CW-1:0]       idx_inc;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  assign tc_wide       = CW'(task_count);
  assign n_eff         = (tc_wide > CW'(MAX_TASKS)) ? CW'(MAX_TASKS) : tc_wide;
  assign slot_wide     = SLW'(slot);
  assign slot_addr     = slot_wide[IW-1:0];
  assign slot_in_range = (int'(slot) < int'(MAX_TASKS));

  assign quantum_eff = (quantum == 16'd0) ? 16'd1 : quantum;
  assign run         = (rdata.remaining < quantum_eff) ? rdata.remaining : quantum_eff;
  assign rem_next    = rdata.remaining - run;
  assign clock_sat   = alu_rsp.carry ? '1 : alu_rsp.sum;
  assign idx_inc     = idx + CW'(1);

  rrs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = clock_now;
    alu_req.b  = '0;
    unique case (state)
      S_CHECK, S_FIN1: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = 32'(rdata.arrival);
      end
      S_RUN: begin
        alu_req.b  = 32'(run);
      end
      S_FIN2: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = tmp;
        alu_req.b  = 32'(rdata.burst);
      end
      S_FIN3: begin
        alu_req.a  = tmp;
        alu_req.b  = 32'(rdata.burst);
      end
      S_TICK: begin
        alu_req.b  = 32'd1;
      end
      default: begin
      end
    endcase
  end

  // table write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[IW-1:0];
    mem_wdata = '{arrival: rdata.arrival, burst: rdata.burst, remaining: rem_next};
    if (state == S_IDLE) begin
      mem_waddr = slot_addr;
      mem_wdata = '{arrival: arrival, burst: burst, remaining: burst};
      mem_we    = accept && (func == FUNC_LOAD) && slot_in_range;
    end else if (state == S_RUN) begin
      mem_we = 1'b1;
    end
  end

  assign rd_en = (state == S_SCAN) && (idx < n_eff);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      strobe          <= 1'b0;
      quantum         <= 16'd1;
      task_count      <= 7'd1;
      clock_now       <= '0;
      scan_position   <= '0;
      pass_found_any  <= 1'b0;
      completed_count <= '0;
      idx             <= '0;
      second_pass     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_QUANTUM:    quantum    <= cfg_data;
          REG_TASK_COUNT: task_count <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (func == FUNC_LOAD) begin
              strobe          <= 1'b1;
              kind            <= KIND_LOAD;
              task_number     <= 7'(slot) + 7'd1;
              clock_after     <= (slot_in_range && slot == 6'd0) ? '0 : clock_now;
              finished        <= 1'b0;
              waiting_time    <= '0;
              turnaround_time <= '0;
              if (slot_in_range && slot == 6'd0) begin
                clock_now       <= '0;
                scan_position   <= '0;
                pass_found_any  <= 1'b0;
                completed_count <= '0;
              end
            end else if (CW'(completed_count) >= n_eff) begin
              strobe          <= 1'b1;
              kind            <= KIND_DONE;
              task_number     <= '0;
              clock_after     <= clock_now;
              finished        <= 1'b0;
              waiting_time    <= '0;
              turnaround_time <= '0;
            end else begin
              idx         <= CW'(scan_position);
              second_pass <= 1'b0;
              if (scan_position == '0) begin
                pass_found_any <= 1'b0;
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx < n_eff) begin
            state <= S_CHECK;
          end else if (pass_found_any && !second_pass) begin
            // wrap around for a fresh pass from slot zero
            second_pass    <= 1'b1;
            idx            <= '0;
            pass_found_any <= 1'b0;
          end else begin
            state <= S_TICK;
          end
        end
        S_CHECK: begin
          if (alu_rsp.carry && rdata.remaining != '0) begin
            state <= S_RUN;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end
        end
        S_RUN: begin
          clock_now      <= clock_sat;
          pass_found_any <= 1'b1;
          scan_position  <= (idx_inc >= n_eff) ? '0 : idx_inc[IW-1:0];
          if (rem_next == '0) begin
            state <= S_FIN1;
          end else begin
            strobe          <= 1'b1;
            kind            <= KIND_GRANT;
            task_number     <= 7'(idx_inc);
            clock_after     <= clock_sat;
            finished        <= 1'b0;
            waiting_time    <= '0;
            turnaround_time <= '0;
            state           <= S_IDLE;
          end
        end
        S_FIN1: begin
          tmp   <= alu_rsp.sum;
          state <= S_FIN2;
        end
        S_FIN2: begin
          // clamp negative waiting time at zero
          tmp   <= alu_rsp.carry ? alu_rsp.sum : '0;
          state <= S_FIN3;
        end
        S_FIN3: begin
          strobe          <= 1'b1;
          kind            <= KIND_GRANT;
          task_number     <= 7'(idx_inc);
          clock_after     <= clock_now;
          finished        <= 1'b1;
          waiting_time    <= tmp;
          turnaround_time <= clock_sat;
          if (completed_count != 7'h7f) begin
            completed_count <= completed_count + 7'd1;
          end
          state <= S_IDLE;
        end
        S_TICK: begin
          clock_now       <= clock_sat;
          scan_position   <= '0;
          pass_found_any  <= 1'b0;
          strobe          <= 1'b1;
          kind            <= KIND_IDLE;
          task_number     <= '0;
          clock_after     <= clock_sat;
          finished        <= 1'b0;
          waiting_time    <= '0;
          turnaround_time <= '0;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result shown while still busy");

  a_strobe_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start || busy))
    else $error("result without a transferred command");

  a_check_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (idx < n_eff))
    else $error("slot check outside the active slots");

  a_clock_grows: assert property (@(posedge clk) disable iff (rst)
    busy |=> (clock_now >= $past(clock_now)))
    else $error("clock went backwards during an advance");

  a_turn_ge_wait: assert property (@(posedge clk) disable iff (rst)
    (strobe && finished) |-> (turnaround_time >= waiting_time))
    else $error("turnaround below waiting time");
`endif

endmodule

// ----- rtl/rrs_alu.sv -----
// ----------------------------------------------------------------------------
// rrs_alu
// shared 32-bit add/subtract unit with carry out (carry set on subtract
// means no borrow)
// ----------------------------------------------------------------------------
module rrs_alu import rrs_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic                sub;
  logic [CLOCK_W-1:0]  b_x;
  logic [CLOCK_W:0]    total;

  assign sub   = (req.op == ALU_SUB);
  assign b_x   = sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_x} + {{CLOCK_W{1'b0}}, sub};

  assign rsp.sum   = total[CLOCK_W-1:0];
  assign rsp.carry = total[CLOCK_W];

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for round_robin_slice_scheduler_core
// ----------------------------------------------------------------------------
// Commands are driven through the start/busy handshake while a local copy of
// the slot table, clock and scan state works out the result that each command
// must produce. Results are taken on strobe and checked field by field against
// the oldest outstanding prediction. Directed cases come first: reset
// defaults, field extremes, idle ticks with a zero burst and a zero quantum,
// and an empty task set. Random scheduling runs follow over several quantum
// and task-count settings, each run loading every scheduled slot before
// advancing, mixed with mid-run reloads and loads to unscheduled slots.
// ----------------------------------------------------------------------------
module tb import rrs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 64;
  localparam int ITEM_TARGET = 1400;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 300;

  typedef struct {
    logic [1:0]  kind;
    logic [6:0]  task_no;
    logic [31:0] clock_after;
    logic        finished;
    logic [31:0] waiting;
    logic [31:0] turnaround;
  } slice_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        func = FUNC_LOAD;
  logic [5:0]  slot = '0;
  logic [15:0] arrival = '0;
  logic [15:0] burst = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_QUANTUM;
  logic [15:0] cfg_data = '0;
  logic        strobe;
  logic [1:0]  kind;
  logic [6:0]  task_number;
  logic [31:0] clock_after;
  logic        finished;
  logic [31:0] waiting_time;
  logic [31:0] turnaround_time;

  // scheduler state as predicted
  logic [15:0] arrival_of [SLOTS];
  logic [15:0] burst_of [SLOTS];
  logic [15:0] left_of [SLOTS];
  logic [31:0] sched_clock = '0;
  int          scan_pos = 0;
  bit          pass_granted = 1'b0;
  int          done_count = 0;
  logic [15:0] quantum_reg = 16'd1;
  logic [6:0]  task_count_reg = 7'd1;

  slice_result_t expected_slices [$];
  int            items_sent = 0;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  bit            steady = 1'b0;

  round_robin_slice_scheduler_core dut (
    .clk, .rst, .start, .busy, .func, .slot, .arrival, .burst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .strobe, .kind, .task_number, .clock_after, .finished,
    .waiting_time, .turnaround_time
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] add_saturated(logic [31:0] x, logic [31:0] y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic slice_result_t schedule_item(logic f, logic [5:0] s,
                                                  logic [15:0] a, logic [15:0] b);
    slice_result_t r;
    int          n;
    int          pos;
    int          p;
    int          k;
    int          pick;
    bit          found;
    int unsigned q;
    int unsigned span;
    longint      w;
    r = '{kind: KIND_LOAD, task_no: '0, clock_after: '0, finished: 1'b0,
          waiting: '0, turnaround: '0};
    if (f == FUNC_LOAD) begin
      arrival_of[s] = a;
      burst_of[s] = b;
      left_of[s] = b;
      if (s == 6'd0) begin
        sched_clock = '0;
        scan_pos = 0;
        pass_granted = 1'b0;
        done_count = 0;
      end
      r.task_no = s + 7'd1;
      r.clock_after = sched_clock;
      return r;
    end
    n = (task_count_reg > 7'd64) ? SLOTS : int'(task_count_reg);
    if (done_count >= n) begin
      r.kind = KIND_DONE;
      r.clock_after = sched_clock;
      return r;
    end
    pos = scan_pos;
    found = 1'b0;
    pick = 0;
    for (p = 0; p < 2; p++) begin
      if (pos == 0) pass_granted = 1'b0;
      for (k = pos; k < n; k++) begin
        if (!found && arrival_of[k] <= sched_clock && left_of[k] != 16'd0) begin
          found = 1'b1;
          pick = k;
        end
      end
      if (found || !pass_granted) break;
      pos = 0;
    end
    if (found) begin
      q = (quantum_reg == 16'd0) ? 1 : quantum_reg;
      span = (left_of[pick] < q) ? left_of[pick] : q;
      sched_clock = add_saturated(sched_clock, span);
      left_of[pick] = left_of[pick] - span[15:0];
      r.kind = KIND_GRANT;
      r.task_no = 7'(pick + 1);
      if (left_of[pick] == 16'd0) begin
        w = longint'({32'd0, sched_clock}) - longint'({48'd0, arrival_of[pick]})
            - longint'({48'd0, burst_of[pick]});
        if (w < 0) w = 0;
        if (w > 64'sd4294967295) w = 64'sd4294967295;
        r.waiting = w[31:0];
        r.turnaround = add_saturated(r.waiting, {16'd0, burst_of[pick]});
        r.finished = 1'b1;
        if (done_count < 127) done_count++;
      end
      pass_granted = 1'b1;
      scan_pos = (pick + 1 >= n) ? 0 : pick + 1;
    end else begin
      sched_clock = add_saturated(sched_clock, 32'd1);
      scan_pos = 0;
      pass_granted = 1'b0;
      r.kind = KIND_IDLE;
    end
    r.clock_after = sched_clock;
    return r;
  endfunction

  function automatic string show_slice(slice_result_t r);
    return $sformatf("kind=%0d task=%0d clock=%0d fin=%0d wait=%0d turn=%0d",
                     r.kind, r.task_no, r.clock_after, r.finished, r.waiting,
                     r.turnaround);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    slice_result_t seen;
    slice_result_t want;
    if (!rst && strobe) begin
      seen = '{kind, task_number, clock_after, finished, waiting_time,
               turnaround_time};
      if (expected_slices.size() == 0) begin
        report_mismatch({"unexpected result: ", show_slice(seen)});
      end else begin
        want = expected_slices.pop_front();
        if (seen.kind !== want.kind || seen.task_no !== want.task_no ||
            seen.clock_after !== want.clock_after ||
            seen.finished !== want.finished || seen.waiting !== want.waiting ||
            seen.turnaround !== want.turnaround) begin
          report_mismatch({"expected ", show_slice(want), " got ", show_slice(seen)});
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic f, logic [5:0] s, logic [15:0] a, logic [15:0] b,
                           output logic [1:0] got_kind);
    slice_result_t r;
    if (!steady && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    slot <= s;
    arrival <= a;
    burst <= b;
    do @(posedge clk); while (busy);
    r = schedule_item(f, s, a, b);
    expected_slices.push_back(r);
    got_kind = r.kind;
    items_sent++;
  endtask

  task automatic advance(output logic [1:0] got_kind);
    send_item(FUNC_ADVANCE, 6'($urandom), 16'($urandom), 16'($urandom), got_kind);
  endtask

  // both registers go in back to back, once the scheduler has drained
  task automatic set_registers(logic [15:0] q, logic [15:0] tc);
    start <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_QUANTUM;
    cfg_data <= q;
    do @(posedge clk); while (!cfg_ready);
    quantum_reg = q;
    cfg_index <= REG_TASK_COUNT;
    cfg_data <= tc;
    do @(posedge clk); while (!cfg_ready);
    task_count_reg = tc[6:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic test_basic_run();
    logic [1:0] got;
    send_item(FUNC_LOAD, 6'd0, 16'd0, 16'd2, got);
    repeat (3) advance(got);
  endtask

  task automatic test_extreme_fields();
    logic [1:0] got;
    set_registers(16'hFFFF, 16'd2);
    send_item(FUNC_LOAD, 6'd63, 16'hFFFF, 16'hFFFF, got);
    send_item(FUNC_LOAD, 6'd1, 16'hFFFF, 16'hFFFF, got);
    send_item(FUNC_LOAD, 6'd0, 16'd0, 16'hFFFF, got);
    repeat (3) advance(got);
  endtask

  task automatic test_idle_and_zero_cases();
    logic [1:0] got;
    set_registers(16'd0, 16'd2);
    send_item(FUNC_LOAD, 6'd1, 16'd0, 16'd0, got);
    send_item(FUNC_LOAD, 6'd0, 16'd3, 16'd1, got);
    repeat (6) advance(got);
  endtask

  task automatic test_empty_task_count();
    logic [1:0] got;
    set_registers(16'd1, 16'd0);
    advance(got);
    send_item(FUNC_LOAD, 6'd42, 16'h5A5A, 16'hA5A5, got);
    advance(got);
  endtask

  task automatic run_schedule(int n);
    logic [1:0]  got;
    logic [15:0] b;
    int          s;
    int          r;
    int          adv_left;
    bit          done_seen;
    for (s = 0; s < n; s++) begin
      r = $urandom_range(99);
      if (r < 75) b = 16'($urandom_range(1, 12));
      else if (r < 87) b = 16'($urandom_range(1, 65535));
      else if (r < 97) b = 16'hFFFF;
      else b = 16'd0;
      send_item(FUNC_LOAD, s[5:0], ($urandom_range(99) < 10) ? 16'd0 :
                16'($urandom_range(0, 2 * n + 4)), b, got);
    end
    adv_left = 3 * n + 16;
    done_seen = 1'b0;
    while (adv_left > 0 && !done_seen) begin
      r = $urandom_range(99);
      if (r < 4 && n < SLOTS) begin
        send_item(FUNC_LOAD, 6'($urandom_range(n, SLOTS - 1)), 16'($urandom),
                  16'($urandom), got);
      end else if (r < 7 && n > 0) begin
        send_item(FUNC_LOAD, 6'($urandom_range(0, n - 1)),
                  16'($urandom_range(0, 2 * n + 4)), 16'($urandom_range(1, 12)), got);
      end else begin
        advance(got);
        adv_left--;
        if (got == KIND_DONE) done_seen = 1'b1;
      end
    end
  endtask

  task automatic test_random_runs();
    logic [15:0] q;
    int          tc;
    int          n;
    int          phase;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin q = 16'd1;     tc = 3;   end
        1: begin q = 16'hFFFF;  tc = 64;  end
        2: begin q = 16'd0;     tc = 5;   end
        3: begin q = 16'd2;     tc = 127; end
        4: begin q = 16'd3;     tc = 1;   end
        5: begin q = 16'($urandom); tc = 8; end
        6: begin q = 16'd1;     tc = 0;   end
        7: begin q = 16'd4;     tc = 12;  end
        default: begin
          q = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 8)) : 16'($urandom);
          tc = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 12);
        end
      endcase
      steady = (phase == 2);
      set_registers(q, {7'($urandom), 2'($urandom), 7'(tc)});
      n = (tc > SLOTS) ? SLOTS : tc;
      repeat ((n > 16) ? 1 : $urandom_range(2, 4)) run_schedule(n);
      steady = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_run();
    test_extreme_fields();
    test_idle_and_zero_cases();
    test_empty_task_count();
    test_random_runs();
    start <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_slices.size() != 0) report_mismatch("results still outstanding");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
